>>> rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// shared constants, codes and controller/datapath interface types for the
// priority sorted queue
// ----------------------------------------------------------------------------
package psq_pkg;

  // table size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int TKT_W    = 16;
  localparam int PRIO_W   = 2;
  localparam int ENT_W    = TKT_W + PRIO_W;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 7;

  // stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // priority levels
  localparam logic [PRIO_W-1:0] PRIO_OTHER = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_RED   = 2'd2;

  // operation selector carried on tuser
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FULL,
    DP_NOT_FOUND,
    DP_INS_START,
    DP_INS_SCAN,
    DP_INS_HEAD,
    DP_RM_START,
    DP_RM_SCAN,
    DP_RM_SHIFT,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  ahead;
    logic  match;
    logic  idx_zero;
    logic  idx_last;
  } dp_status_t;

endpackage

>>> rtl/psq_datapath.sv
// ----------------------------------------------------------------------------
// psq_datapath
// entry memory, request and result registers, scan index and compares
// ----------------------------------------------------------------------------
module psq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  psq_pkg::dp_cmd_t                cmd,
  output psq_pkg::dp_status_t             status,
  input  logic [psq_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                            in_user,
  output logic [psq_pkg::OUT_DATA_W-1:0]  out_data
);

  // entry memory: ticket in low bits, priority above
  logic [psq_pkg::ENT_W-1:0]   mem [psq_pkg::CAPACITY];
  logic [psq_pkg::ENT_W-1:0]   rd_data;

  logic                         rd_en;
  logic [psq_pkg::ADDR_W-1:0]  rd_addr;
  logic                         wr_en;
  logic [psq_pkg::ADDR_W-1:0]  wr_addr;
  logic [psq_pkg::ENT_W-1:0]   wr_data;

  // request
  psq_pkg::mode_t               req_mode;
  logic [psq_pkg::TKT_W-1:0]   req_ticket;
  logic [psq_pkg::PRIO_W-1:0]  req_prio;
  logic [psq_pkg::PRIO_W-1:0]  in_prio;

  // scan and result
  logic [psq_pkg::CNT_W-1:0]   count;
  logic [psq_pkg::CNT_W-1:0]   count_next;
  logic [psq_pkg::ADDR_W-1:0]  idx;
  logic [psq_pkg::ADDR_W-1:0]  idx_next;
  logic [psq_pkg::ADDR_W-1:0]  idx_up;
  logic [psq_pkg::ADDR_W-1:0]  idx_dn;
  psq_pkg::status_t             res_status;
  psq_pkg::status_t             res_status_next;
  logic [psq_pkg::ADDR_W-1:0]  res_pos;
  logic [psq_pkg::ADDR_W-1:0]  res_pos_next;

  logic [psq_pkg::TKT_W-1:0]   ent_tkt;
  logic [psq_pkg::PRIO_W-1:0]  ent_prio;
  logic [psq_pkg::ENT_W-1:0]   new_entry;

  assign ent_tkt   = rd_data[psq_pkg::TKT_W-1:0];
  assign ent_prio  = rd_data[psq_pkg::ENT_W-1:psq_pkg::TKT_W];
  assign new_entry = {req_prio, req_ticket};
  assign idx_up    = idx + psq_pkg::ADDR_W'(1);
  assign idx_dn    = idx - psq_pkg::ADDR_W'(1);

  // code three names no colour, so it orders as any other colour
  assign in_prio = (in_data[psq_pkg::ENT_W-1:psq_pkg::TKT_W] > psq_pkg::PRIO_RED) ?
                   psq_pkg::PRIO_OTHER : in_data[psq_pkg::ENT_W-1:psq_pkg::TKT_W];

  assign status.mode     = req_mode;
  assign status.empty    = (count == '0);
  assign status.full     = (count >= psq_pkg::CNT_W'(psq_pkg::CAPACITY));
  assign status.ahead    = (ent_prio > req_prio) ||
                           ((ent_prio == req_prio) && (ent_tkt <= req_ticket));
  assign status.match    = (ent_tkt == req_ticket);
  assign status.idx_zero = (idx == '0);
  assign status.idx_last = ((psq_pkg::CNT_W'(idx) + psq_pkg::CNT_W'(1)) == count);

  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = new_entry;
    idx_next        = idx;
    count_next      = count;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    unique case (cmd.op)
      psq_pkg::DP_FULL: begin
        res_status_next = psq_pkg::ST_FULL;
        res_pos_next    = '0;
      end
      psq_pkg::DP_NOT_FOUND: begin
        res_status_next = psq_pkg::ST_NOT_FOUND;
        res_pos_next    = '0;
      end
      psq_pkg::DP_INS_START: begin
        // scan from the tail toward the head
        rd_en    = 1'b1;
        rd_addr  = psq_pkg::ADDR_W'(count - psq_pkg::CNT_W'(1));
        idx_next = rd_addr;
      end
      psq_pkg::DP_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = idx_up;
        if (status.ahead) begin
          wr_data         = new_entry;
          res_status_next = psq_pkg::ST_INSERTED;
          res_pos_next    = idx_up;
          count_next      = count + psq_pkg::CNT_W'(1);
        end else begin
          wr_data  = rd_data;
          rd_en    = 1'b1;
          rd_addr  = idx_dn;
          idx_next = idx_dn;
        end
      end
      psq_pkg::DP_INS_HEAD: begin
        wr_en           = 1'b1;
        wr_addr         = '0;
        wr_data         = new_entry;
        res_status_next = psq_pkg::ST_INSERTED;
        res_pos_next    = '0;
        count_next      = count + psq_pkg::CNT_W'(1);
      end
      psq_pkg::DP_RM_START: begin
        rd_en    = 1'b1;
        rd_addr  = '0;
        idx_next = '0;
      end
      psq_pkg::DP_RM_SCAN: begin
        rd_en    = 1'b1;
        rd_addr  = idx_up;
        idx_next = idx_up;
        if (status.match) begin
          res_status_next = psq_pkg::ST_REMOVED;
          res_pos_next    = idx;
          if (status.idx_last) begin
            count_next = count - psq_pkg::CNT_W'(1);
          end
        end else if (status.idx_last) begin
          res_status_next = psq_pkg::ST_NOT_FOUND;
          res_pos_next    = '0;
        end
      end
      psq_pkg::DP_RM_SHIFT: begin
        // pull each later entry one place toward the head
        wr_en    = 1'b1;
        wr_addr  = idx_dn;
        wr_data  = rd_data;
        rd_en    = 1'b1;
        rd_addr  = idx_up;
        idx_next = idx_up;
        if (status.idx_last) begin
          count_next = count - psq_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (cmd.op == psq_pkg::DP_LOAD) begin
      req_mode   <= psq_pkg::mode_t'(in_user);
      req_ticket <= in_data[psq_pkg::TKT_W-1:0];
      req_prio   <= in_prio;
    end
    if (cmd.op == psq_pkg::DP_EMIT) begin
      out_data <= {psq_pkg::POS_W'(count), psq_pkg::POS_W'(res_pos), res_status};
    end
  end

endmodule

>>> rtl/psq_ctrl.sv
// ----------------------------------------------------------------------------
// psq_ctrl
// sequencer for insert and remove scans, and output word handshake
// ----------------------------------------------------------------------------
module psq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psq_pkg::dp_cmd_t     cmd,
  input  psq_pkg::dp_status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SCAN,
    S_INS_HEAD,
    S_RM_SCAN,
    S_RM_SHIFT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = psq_pkg::DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = psq_pkg::DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.mode == psq_pkg::MODE_INSERT) begin
          priority if (status.full) begin
            cmd.op     = psq_pkg::DP_FULL;
            state_next = S_EMIT;
          end else if (status.empty) begin
            cmd.op     = psq_pkg::DP_INS_HEAD;
            state_next = S_EMIT;
          end else begin
            cmd.op     = psq_pkg::DP_INS_START;
            state_next = S_INS_SCAN;
          end
        end else begin
          if (status.empty) begin
            cmd.op     = psq_pkg::DP_NOT_FOUND;
            state_next = S_EMIT;
          end else begin
            cmd.op     = psq_pkg::DP_RM_START;
            state_next = S_RM_SCAN;
          end
        end
      end
      S_INS_SCAN: begin
        cmd.op = psq_pkg::DP_INS_SCAN;
        priority if (status.ahead) begin
          state_next = S_EMIT;
        end else if (status.idx_zero) begin
          state_next = S_INS_HEAD;
        end
      end
      S_INS_HEAD: begin
        cmd.op     = psq_pkg::DP_INS_HEAD;
        state_next = S_EMIT;
      end
      S_RM_SCAN: begin
        cmd.op = psq_pkg::DP_RM_SCAN;
        priority if (status.idx_last) begin
          state_next = S_EMIT;
        end else if (status.match) begin
          state_next = S_RM_SHIFT;
        end
      end
      S_RM_SHIFT: begin
        cmd.op = psq_pkg::DP_RM_SHIFT;
        if (status.idx_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op     = psq_pkg::DP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == psq_pkg::DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/priority_sorted_queue_top.sv
// ----------------------------------------------------------------------------
// priority_sorted_queue_top
// bounded table kept sorted by priority (high first) then ticket (low first),
// with insert and remove-by-ticket requests, one status word per request
// ----------------------------------------------------------------------------
//
//  channel  dir  fields (low bit first)                    meaning
//  -------  ---  ----------------------------------------  ----------------------
//  s_*      in   tdata: ticket[15:0] priority_level[17:16]  request word
//                tuser: mode (0 insert, 1 remove)
//  m_*      out  tdata: status_code[1:0] position[8:2]      result word
//                       entry_count[15:9]
//
//  a request works through the entries held one entry a cycle: each step
//  reads the entry memory once and, while inserting or shifting, writes it
//  once; a full-table insert or a remove on an empty table needs no search
//  one request is worked at a time; s_tready is high only while no request
//  is in progress, and a result word held by m_tready low only holds the
//  block at its last step
//  rst (synchronous) empties the table; no memory clearing pass is needed
//
module priority_sorted_queue_top (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [psq_pkg::IN_DATA_W-1:0]   s_tdata,   // ticket, priority_level
  input  logic                            s_tuser,   // mode
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psq_pkg::OUT_DATA_W-1:0]  m_tdata    // status_code, position, entry_count
);

  // command and status between sequencer and datapath
  psq_pkg::dp_cmd_t    cmd;
  psq_pkg::dp_status_t status;

  // sequencer: owns request acceptance and result word valid
  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: entry memory, scan index, count and result word
  psq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_data (m_tdata)
  );

endmodule
